/* rtl/cft_pkg.sv */
package cft_pkg;

  // Character codes
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChComma     = 8'h2C;
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChCr        = 8'h0D;
  localparam logic [7:0] ChLf        = 8'h0A;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChSpace     = 8'h20;

  // Length of the table-end literal, and counter widths that follow from it
  localparam int EndWordLen = 8;
  localparam int ReplayW    = $clog2(EndWordLen);
  // At most three results follow the replayed literal prefix within one byte
  localparam int TailMax    = 3;
  localparam int TailCntW   = $clog2(TailMax + 1);
  localparam int SeqW       = $clog2(EndWordLen + TailMax);

  localparam int QueueDepth = 2;
  localparam int PtrW       = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    KIND_BYTE      = 2'd0,
    KIND_FIELD_END = 2'd1,
    KIND_TABLE_END = 2'd2
  } item_kind_e;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_SKIP  = 2'd1,
    MODE_FIELD = 2'd2,
    MODE_DROP  = 2'd3
  } scan_mode_e;

  typedef struct packed {
    item_kind_e  kind;
    logic [7:0]  data;
  } item_t;

  // Work for one input byte: a replayed literal prefix, then a short tail
  typedef struct packed {
    logic [ReplayW-1:0]     replay_cnt;
    logic [TailCntW-1:0]    tail_cnt;
    item_t [TailMax-1:0]    tail;
  } desc_t;

  function automatic logic [7:0] end_word_byte(logic [ReplayW-1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h54; // T
      3'd1:    ch = 8'h61; // a
      3'd2:    ch = 8'h62; // b
      3'd3:    ch = 8'h6C; // l
      3'd4:    ch = 8'h65; // e
      3'd5:    ch = 8'h45; // E
      3'd6:    ch = 8'h6E; // n
      default: ch = 8'h64; // d
    endcase
    return ch;
  endfunction

endpackage

/* rtl/cft_front.sv */
module cft_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          in_byte_i,
  input  logic                in_eos_i,
  input  logic                full_i,
  output logic                push_o,
  output cft_pkg::desc_t      desc_o
);

  typedef struct packed {
    cft_pkg::scan_mode_e mode;
    logic                quoted;
    logic                bsl;
    logic                sl;
    logic                fne;
  } st_t;

  typedef struct packed {
    st_t                                   st;
    logic [cft_pkg::TailCntW-1:0]          cnt;
    cft_pkg::item_t [cft_pkg::TailMax-1:0] item;
  } work_t;

  function automatic work_t put(work_t w, cft_pkg::item_kind_e k, logic [7:0] b);
    work_t r;
    r = w;
    if (w.cnt < cft_pkg::TailCntW'(cft_pkg::TailMax)) begin
      r.item[w.cnt] = '{kind: k, data: b};
      r.cnt         = w.cnt + cft_pkg::TailCntW'(1);
    end
    return r;
  endfunction

  function automatic work_t field_byte(work_t w, logic [7:0] b);
    work_t r;
    r        = put(w, cft_pkg::KIND_BYTE, b);
    r.st.fne = 1'b1;
    return r;
  endfunction

  function automatic work_t close_field(work_t w, cft_pkg::scan_mode_e nxt);
    work_t r;
    r = w;
    if (w.st.fne) begin
      r = put(r, cft_pkg::KIND_FIELD_END, 8'h00);
    end
    r.st.fne    = 1'b0;
    r.st.quoted = 1'b0;
    r.st.bsl    = 1'b0;
    r.st.sl     = 1'b0;
    r.st.mode   = nxt;
    return r;
  endfunction

  function automatic work_t in_field(work_t w, logic [7:0] b);
    work_t r;
    logic  done;
    r    = w;
    done = 1'b0;
    if (r.st.bsl) begin
      r.st.bsl = 1'b0;
      r = field_byte(r, b);
      if (b == cft_pkg::ChLf) begin
        r = close_field(r, cft_pkg::MODE_START);
      end
    end else begin
      if (r.st.sl) begin
        r.st.sl = 1'b0;
        if (b == cft_pkg::ChSlash) begin
          r    = close_field(r, cft_pkg::MODE_DROP);
          done = 1'b1;
        end else begin
          r = field_byte(r, cft_pkg::ChSlash);
        end
      end
      if (!done) begin
        if (b == cft_pkg::ChQuote) begin
          r.st.quoted = ~r.st.quoted;
        end else if (r.st.quoted) begin
          if (b == cft_pkg::ChBackslash) begin
            r.st.bsl = 1'b1;
          end else begin
            r = field_byte(r, b);
            if (b == cft_pkg::ChLf) begin
              r = close_field(r, cft_pkg::MODE_START);
            end
          end
        end else if (b == cft_pkg::ChSlash) begin
          r.st.sl = 1'b1;
        end else if (b == cft_pkg::ChCr) begin
          r = close_field(r, cft_pkg::MODE_DROP);
        end else if (b == cft_pkg::ChLf || b == cft_pkg::ChComma) begin
          r = close_field(r, cft_pkg::MODE_START);
        end else begin
          r = field_byte(r, b);
        end
      end
    end
    return r;
  endfunction

  function automatic work_t skip_blanks(work_t w, logic [7:0] b);
    work_t r;
    r = w;
    if (b != cft_pkg::ChSpace && b != cft_pkg::ChTab) begin
      r.st.mode = cft_pkg::MODE_FIELD;
      r = in_field(r, b);
    end
    return r;
  endfunction

  st_t                         st_q, st_d;
  logic [cft_pkg::ReplayW-1:0] mc_q, mc_d;
  logic [cft_pkg::ReplayW-1:0] rcnt;
  work_t                       w;
  logic                        accept;

  assign in_ready_o = ~full_i;
  assign accept     = in_valid_i & ~full_i;

  always_comb begin
    w.st   = st_q;
    w.cnt  = '0;
    w.item = '0;
    mc_d   = mc_q;
    rcnt   = '0;

    unique case (st_q.mode)
      cft_pkg::MODE_START: begin
        if (in_byte_i == cft_pkg::end_word_byte(mc_q)) begin
          if (mc_q == cft_pkg::ReplayW'(cft_pkg::EndWordLen - 1)) begin
            mc_d      = '0;
            w         = put(w, cft_pkg::KIND_TABLE_END, 8'h00);
            w.st.mode = cft_pkg::MODE_DROP;
          end else begin
            mc_d = mc_q + cft_pkg::ReplayW'(1);
          end
        end else if (mc_q != '0) begin
          // Replay the held prefix as field bytes, then treat this byte normally
          rcnt      = mc_q;
          mc_d      = '0;
          w.st.fne  = 1'b1;
          w.st.mode = cft_pkg::MODE_FIELD;
          w         = in_field(w, in_byte_i);
        end else begin
          w.st.mode = cft_pkg::MODE_SKIP;
          w         = skip_blanks(w, in_byte_i);
        end
      end
      cft_pkg::MODE_SKIP:  w = skip_blanks(w, in_byte_i);
      cft_pkg::MODE_FIELD: w = in_field(w, in_byte_i);
      cft_pkg::MODE_DROP: begin
        if (in_byte_i == cft_pkg::ChLf) begin
          w.st.mode = cft_pkg::MODE_START;
        end
      end
    endcase

    // Flush at end of stream and return to the reset state
    if (in_eos_i) begin
      if (w.st.mode == cft_pkg::MODE_START && mc_d != '0) begin
        rcnt     = mc_d;
        w.st.fne = 1'b1;
      end
      if (w.st.sl) begin
        w.st.sl = 1'b0;
        w       = field_byte(w, cft_pkg::ChSlash);
      end
      if (w.st.fne) begin
        w = put(w, cft_pkg::KIND_FIELD_END, 8'h00);
      end
      w.st.mode   = cft_pkg::MODE_START;
      w.st.quoted = 1'b0;
      w.st.bsl    = 1'b0;
      w.st.sl     = 1'b0;
      w.st.fne    = 1'b0;
      mc_d        = '0;
    end

    st_d = w.st;
  end

  assign desc_o.replay_cnt = rcnt;
  assign desc_o.tail_cnt   = w.cnt;
  assign desc_o.tail       = w.item;
  assign push_o            = accept & ((rcnt != '0) | (w.cnt != '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{mode: cft_pkg::MODE_START, default: 1'b0};
      mc_q <= '0;
    end else if (accept) begin
      st_q <= st_d;
      mc_q <= mc_d;
    end
  end

endmodule

/* rtl/cft_queue.sv */
module cft_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cft_pkg::desc_t desc_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output cft_pkg::desc_t head_o
);

  cft_pkg::desc_t                mem_q [cft_pkg::QueueDepth];
  logic [cft_pkg::PtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [cft_pkg::QCntW-1:0]     cnt_q;

  assign full_o  = (cnt_q == cft_pkg::QCntW'(cft_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + cft_pkg::PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + cft_pkg::PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + cft_pkg::QCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - cft_pkg::QCntW'(1);
      end
    end
  end

endmodule

/* rtl/cft_back.sv */
module cft_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  cft_pkg::desc_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output cft_pkg::item_t out_item_o,
  output logic           out_last_o
);

  logic [cft_pkg::SeqW-1:0]     idx_q, idx_d;
  logic [cft_pkg::SeqW-1:0]     replay_ext, total;
  logic [cft_pkg::TailCntW-1:0] tidx;
  logic                         load, is_last;
  cft_pkg::item_t               item;
  logic                         out_valid_q;
  cft_pkg::item_t               out_item_q;
  logic                         out_last_q;

  assign replay_ext = cft_pkg::SeqW'(head_i.replay_cnt);
  assign total      = replay_ext + cft_pkg::SeqW'(head_i.tail_cnt);
  assign is_last    = (idx_q == total - cft_pkg::SeqW'(1));
  assign tidx       = cft_pkg::TailCntW'(idx_q - replay_ext);
  assign load       = ~empty_i & (~out_valid_q | out_ready_i);
  assign pop_o      = load & is_last;

  always_comb begin
    if (idx_q < replay_ext) begin
      item.kind = cft_pkg::KIND_BYTE;
      item.data = cft_pkg::end_word_byte(cft_pkg::ReplayW'(idx_q));
    end else begin
      item = head_i.tail[tidx];
    end
    idx_d = idx_q;
    if (load) begin
      idx_d = is_last ? '0 : idx_q + cft_pkg::SeqW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_item_q <= item;
      out_last_q <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign out_last_o  = out_last_q;

endmodule

/* rtl/csv_field_tokenizer.sv */
// A byte's results are registered first in the descriptor queue, then in the output register.
// Throughput: one input byte per cycle while each byte yields at most one result and the master
// side accepts; the output register moves one result per cycle while m_axis_tready stays high.
// A two-entry descriptor queue between the classifier and the output sequencer absorbs bursts.
// Reset (rst_ni low, asynchronous): scanner back at field start, queue empty, no output valid.
module csv_field_tokenizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Slave side: one text byte per transfer
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // end_of_stream
  // Master side: one result per transfer
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [1:0] m_axis_tuser,   // [1:0] kind
  output logic       m_axis_tlast    // last result caused by the input byte
);

  logic           push, full, pop, empty;
  cft_pkg::desc_t desc, head;
  cft_pkg::item_t out_item;

  // Front: classify each byte, update the scan state and describe its results
  cft_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_eos_i   (s_axis_tlast),
    .full_i     (full),
    .push_o     (push),
    .desc_o     (desc)
  );

  // Hold descriptors so that front and back stall independently
  cft_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (desc),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  // Back: expand descriptors into the output register, one result per cycle unless stalled
  cft_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_item_o  (out_item),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = out_item.data;
  assign m_axis_tuser = out_item.kind;

endmodule
